// ----- rtl/core/burning_ship_escape_count_core_assert.svh -----
// Assertion macros used by the core's top-level RTL file.
`ifndef BURNING_SHIP_ESCAPE_COUNT_CORE_ASSERT_SVH
`define BURNING_SHIP_ESCAPE_COUNT_CORE_ASSERT_SVH

// The property holds in the same cycle as its trigger.
`define BSEC_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// The property holds in the cycle after its trigger.
`define BSEC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ----- rtl/core/bsec_pkg.sv -----
package bsec_pkg;

   // Default widths and register values.
   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int CSR_WIDTH           = 16;
   localparam int LIMIT_RESET         = 64;

   // Integer bits of the coordinate format; the rest are fraction bits.
   localparam int INT_BITS = 4;

   // Widest operand the multiplier takes in one cycle.
   localparam int MUL_CHUNK_MAX = 32;

   // Chunk offset of a partial product (operands split in at most two chunks).
   localparam int OFFSET_WIDTH = 2;

   // Iteration sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WAIT,
      ST_TEST,
      ST_FINISH
   } state_type;

   // The three products formed for each iteration.
   typedef enum logic [1:0] {
      PROD_RE_SQ,
      PROD_IM_SQ,
      PROD_CROSS
   } prod_type;

   // Control that travels with one partial product down the multiplier pipe.
   typedef struct packed {
      logic                    valid;
      logic                    first;
      logic                    last;
      prod_type                dest;
      logic [OFFSET_WIDTH-1:0] offset;
   } mul_tag_type;

endpackage

// ----- rtl/core/bsec_if.sv -----
// Point channel: one complex point c per item.
interface bsec_req_if #(
   parameter int COORD_WIDTH = bsec_pkg::COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] c_real;
   logic signed [COORD_WIDTH-1:0] c_imag;

   modport source (output valid, output c_real, output c_imag, input ready);
   modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

// Result channel: one escape count per item.
interface bsec_rsp_if #(
   parameter int COUNT_WIDTH = bsec_pkg::COUNT_WIDTH_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] escape_count;

   modport source (output valid, output escape_count, input ready);
   modport sink   (input valid, input escape_count, output ready);
endinterface

// ----- rtl/core/bsec_mul.sv -----
// Shared multiplier. On start it forms |Re z|^2, |Im z|^2 and |Re z|*|Im z|
// from chunk partial products, one per cycle, and pulses done when all
// three exact products are ready.
module bsec_mul #(
   parameter int OP_WIDTH = bsec_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [OP_WIDTH-1:0]     mag_re,
   input  logic [OP_WIDTH-1:0]     mag_im,
   output logic                    done,
   output logic [2*OP_WIDTH-1:0]   sq_re,
   output logic [2*OP_WIDTH-1:0]   sq_im,
   output logic [2*OP_WIDTH-1:0]   cross_prod
);
   import bsec_pkg::*;

   localparam int NCH      = (OP_WIDTH + MUL_CHUNK_MAX - 1) / MUL_CHUNK_MAX;
   localparam int CW       = (OP_WIDTH + NCH - 1) / NCH;
   localparam int PADW     = NCH * CW;
   localparam int ACCW     = 2 * PADW;
   localparam int IDXW     = (NCH > 1) ? $clog2(NCH) : 1;
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(NCH - 1);

   logic              busy_ff, busy_in;
   logic [PADW-1:0]   ra_ff, ra_in;
   logic [PADW-1:0]   rb_ff, rb_in;
   prod_type          prod_ff, prod_in;
   logic [IDXW-1:0]   ia_ff, ia_in;
   logic [IDXW-1:0]   ib_ff, ib_in;
   mul_tag_type       tag_ff, tag_in;
   logic [2*CW-1:0]   pp_ff, pp_in;
   logic [ACCW-1:0]   acc_re_ff, acc_re_in;
   logic [ACCW-1:0]   acc_im_ff, acc_im_in;
   logic [ACCW-1:0]   acc_x_ff, acc_x_in;
   logic              done_ff, done_in;

   logic [PADW-1:0]   x_op, y_op;
   logic [CW-1:0]     x_chunk, y_chunk;
   logic [ACCW-1:0]   acc_base, acc_add, acc_sum;

   // Operand selection for the product being issued.
   always_comb begin
      case (prod_ff)
         PROD_RE_SQ: begin
            x_op = ra_ff;
            y_op = ra_ff;
         end
         PROD_IM_SQ: begin
            x_op = rb_ff;
            y_op = rb_ff;
         end
         default: begin
            x_op = ra_ff;
            y_op = rb_ff;
         end
      endcase
      x_chunk = x_op[CW*ia_ff +: CW];
      y_chunk = y_op[CW*ib_ff +: CW];
      pp_in   = {CW'(0), x_chunk} * {CW'(0), y_chunk};
   end

   // Issue sequencer: chunk of y inner, chunk of x outer, product outermost.
   always_comb begin
      busy_in = busy_ff;
      ra_in   = ra_ff;
      rb_in   = rb_ff;
      prod_in = prod_ff;
      ia_in   = ia_ff;
      ib_in   = ib_ff;

      tag_in.valid  = busy_ff;
      tag_in.first  = (ia_ff == '0) && (ib_ff == '0);
      tag_in.last   = (prod_ff == PROD_CROSS) && (ia_ff == LAST_IDX) && (ib_ff == LAST_IDX);
      tag_in.dest   = prod_ff;
      tag_in.offset = OFFSET_WIDTH'(ia_ff) + OFFSET_WIDTH'(ib_ff);

      if (start) begin
         busy_in = 1'b1;
         ra_in   = PADW'(mag_re);
         rb_in   = PADW'(mag_im);
         prod_in = PROD_RE_SQ;
         ia_in   = '0;
         ib_in   = '0;
      end else if (busy_ff) begin
         if (ib_ff == LAST_IDX) begin
            ib_in = '0;
            if (ia_ff == LAST_IDX) begin
               ia_in = '0;
               case (prod_ff)
                  PROD_RE_SQ: prod_in = PROD_IM_SQ;
                  PROD_IM_SQ: prod_in = PROD_CROSS;
                  default: begin
                     prod_in = PROD_RE_SQ;
                     busy_in = 1'b0;
                  end
               endcase
            end else begin
               ia_in = ia_ff + 1'b1;
            end
         end else begin
            ib_in = ib_ff + 1'b1;
         end
      end
   end

   // Accumulation of the registered partial product into its product.
   always_comb begin
      case (tag_ff.dest)
         PROD_RE_SQ: acc_base = acc_re_ff;
         PROD_IM_SQ: acc_base = acc_im_ff;
         default:    acc_base = acc_x_ff;
      endcase
      if (tag_ff.first) begin
         acc_base = '0;
      end
      acc_add = ACCW'(pp_ff) << (CW * tag_ff.offset);
      acc_sum = acc_base + acc_add;

      acc_re_in = acc_re_ff;
      acc_im_in = acc_im_ff;
      acc_x_in  = acc_x_ff;
      if (tag_ff.valid) begin
         case (tag_ff.dest)
            PROD_RE_SQ: acc_re_in = acc_sum;
            PROD_IM_SQ: acc_im_in = acc_sum;
            default:    acc_x_in  = acc_sum;
         endcase
      end
      done_in = tag_ff.valid && tag_ff.last;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         tag_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         tag_ff  <= tag_in;
         done_ff <= done_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      prod_ff       <= prod_in;
      ia_ff         <= ia_in;
      ib_ff         <= ib_in;
      pp_ff         <= pp_in;
      acc_re_ff     <= acc_re_in;
      acc_im_ff     <= acc_im_in;
      acc_x_ff      <= acc_x_in;
   end

   assign done       = done_ff;
   assign sq_re      = acc_re_ff[2*OP_WIDTH-1:0];
   assign sq_im      = acc_im_ff[2*OP_WIDTH-1:0];
   assign cross_prod = acc_x_ff[2*OP_WIDTH-1:0];

endmodule

// ----- rtl/core/burning_ship_escape_count_core.sv -----
// Burning Ship escape-time core. Each item is a point c in signed fixed point
// with four integer bits (Q4.28 at the default width); the core iterates
// z <- (|Re z| + i|Im z|)^2 + c from z = 0 and returns the zero-based
// iteration at which |z|^2 first exceeds 4, or the programmed iteration limit
// if the point never escapes. The limit is written through the csr port
// (reset value 64) and must only change while the core is idle. One shared
// multiplier forms |Re z|^2, |Im z|^2 and |Re z|*|Im z| for each iteration as
// 3*K*K partial products, K = 1 for coordinates up to 32 bits and 2 for 33 to
// 64 bits; a zero limit answers zero without running an iteration. The core
// accepts one point at a time; a finished count sits in an output register, so
// the next point may start while the previous count waits to be taken.
module burning_ship_escape_count_core #(
   parameter int COORD_WIDTH = bsec_pkg::COORD_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH = bsec_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   bsec_req_if.sink                       req,
   bsec_rsp_if.source                     rsp,
   input  logic                           csr_write_enable,
   input  logic [bsec_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import bsec_pkg::*;

`include "burning_ship_escape_count_core_assert.svh"

   localparam int FRAC  = COORD_WIDTH - INT_BITS;
   localparam int ZW    = COORD_WIDTH + 1;
   localparam int MAGW  = COORD_WIDTH;
   localparam int PRODW = 2 * MAGW;
   localparam int SUMW  = PRODW + 1;
   localparam logic [SUMW-1:0] ESC_LIMIT = SUMW'(1) << (2 * FRAC + 2);

   state_type                     state_ff, state_in;
   logic [COUNT_WIDTH-1:0]        limit_ff, limit_in;
   logic signed [COORD_WIDTH-1:0] cr_ff, cr_in;
   logic signed [COORD_WIDTH-1:0] ci_ff, ci_in;
   logic signed [ZW-1:0]          zr_ff, zr_in;
   logic signed [ZW-1:0]          zi_ff, zi_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0]        rsp_count_ff, rsp_count_in;

   logic                   accept, rsp_free, rsp_load, req_ready, mul_start, mul_done;
   logic [MAGW-1:0]        mag_re, mag_im;
   logic [PRODW-1:0]       sq_re, sq_im, cross_prod;
   logic [SUMW-1:0]        mag_sum;
   logic                   escaped, last_iter;
   logic [COUNT_WIDTH-1:0] count_next;
   logic signed [ZW-1:0]   aa, bb, ab2;
   logic signed [ZW:0]     re_sum, im_sum;

   assign accept   = req.valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   // Magnitudes of the current z feed the shared multiplier.
   assign mag_re = zr_ff[ZW-1] ? MAGW'(-zr_ff) : MAGW'(zr_ff);
   assign mag_im = zi_ff[ZW-1] ? MAGW'(-zi_ff) : MAGW'(zi_ff);

   bsec_mul #(
      .OP_WIDTH (MAGW)
   ) u_mul (
      .clock      (clock),
      .reset      (reset),
      .start      (mul_start),
      .mag_re     (mag_re),
      .mag_im     (mag_im),
      .done       (mul_done),
      .sq_re      (sq_re),
      .sq_im      (sq_im),
      .cross_prod (cross_prod)
   );

   // Escape test on the exact squares, and the next z from the same products.
   always_comb begin
      mag_sum    = SUMW'(sq_re) + SUMW'(sq_im);
      escaped    = mag_sum > ESC_LIMIT;
      count_next = COUNT_WIDTH'(count_ff + 1'b1);
      last_iter  = count_next == limit_ff;
      aa         = $signed({1'b0, sq_re[FRAC +: MAGW]});
      bb         = $signed({1'b0, sq_im[FRAC +: MAGW]});
      ab2        = $signed({1'b0, cross_prod[FRAC-1 +: MAGW]});
      re_sum     = (ZW+1)'(aa) - (ZW+1)'(bb) + (ZW+1)'(cr_ff);
      im_sum     = (ZW+1)'(ab2) + (ZW+1)'(ci_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (limit_ff == '0) ? ST_FINISH : ST_START;
            end
         end
         ST_START: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mul_done) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            state_in = (escaped || last_iter) ? ST_FINISH : ST_START;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_START:  mul_start = 1'b1;
         ST_FINISH: rsp_load  = rsp_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      limit_in     = limit_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;

      if (csr_write_enable) begin
         limit_in = COUNT_WIDTH'(csr_write_data);
      end

      // The first iteration from z = 0 gives z = c.
      if (accept) begin
         cr_in    = req.c_real;
         ci_in    = req.c_imag;
         zr_in    = ZW'(req.c_real);
         zi_in    = ZW'(req.c_imag);
         count_in = '0;
      end

      if ((state_ff == ST_TEST) && !escaped) begin
         count_in = count_next;
         if (!last_iter) begin
            zr_in = re_sum[ZW-1:0];
            zi_in = im_sum[ZW-1:0];
         end
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= COUNT_WIDTH'(LIMIT_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req.ready        = req_ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.escape_count = rsp_count_ff;

   // The multiplier only reports back while the sequencer waits for it.
   `BSEC_ASSERT_IMPLY(a_done_in_wait, clock, reset, mul_done, state_ff == ST_WAIT, "multiplier done outside wait state")
   // The iteration count never runs past the limit while a point is in work.
   `BSEC_ASSERT_IMPLY(a_count_in_range, clock, reset, state_ff != ST_IDLE, count_ff <= limit_ff, "iteration count beyond limit")
   // A finished count lands in the output register and frees the core.
   `BSEC_ASSERT_NEXT(a_result_loaded, clock, reset, rsp_load, rsp_valid_ff && (state_ff == ST_IDLE), "finished count not loaded")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

   localparam int CW    = bsec_pkg::COORD_WIDTH_DEFAULT;
   localparam int NW    = bsec_pkg::COUNT_WIDTH_DEFAULT;
   localparam int CSRW  = bsec_pkg::CSR_WIDTH;
   localparam int FRAC  = CW - bsec_pkg::INT_BITS;
   localparam int ONE   = 1 << FRAC;
   localparam int TWO   = 2 << FRAC;
   localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

   // Cycle budget; the slowest legal run stays well below it.
   localparam int unsigned CYCLE_LIMIT = 8_000_000;

   localparam int PHASE_COUNT = 6;
   localparam int PHASE_ITEMS = 215;

   // Receiver stall patterns.
   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_HALF,
      DRAIN_SPARSE,
      DRAIN_PERIODIC
   } drain_mode_type;

   // Holds the escape counts still owed by the core and computes new ones.
   class escape_count_board;
      logic [NW-1:0] iter_limit;
      logic [NW-1:0] expected_counts[$];
      int unsigned   mismatches;

      function new();
         iter_limit = NW'(bsec_pkg::LIMIT_RESET);
         mismatches = 0;
      endfunction

      function void set_limit(logic [bsec_pkg::CSR_WIDTH-1:0] value);
         iter_limit = NW'(value);
      endfunction

      // Magnitude of a coordinate, widened so that squares never wrap.
      function logic [127:0] magnitude_wide(longint v);
         longint m;
         m = (v < 0) ? -v : v;
         return 128'(m);
      endfunction

      // Runs the Burning Ship iteration for one point and returns its count.
      function logic [NW-1:0] predict_escape_count(logic signed [CW-1:0] cr,
                                                    logic signed [CW-1:0] ci);
         longint       c_re, c_im, z_re, z_im, sq_re, sq_im, cross_term;
         logic [127:0] mag_re, mag_im, bound;
         int unsigned  iter;
         c_re  = cr;
         c_im  = ci;
         z_re  = 0;
         z_im  = 0;
         iter  = 0;
         bound = 128'd1 << (2 * FRAC + 2);
         while (iter < iter_limit) begin
            mag_re     = magnitude_wide(z_re);
            mag_im     = magnitude_wide(z_im);
            sq_re      = longint'((mag_re * mag_re) >> FRAC);
            sq_im      = longint'((mag_im * mag_im) >> FRAC);
            cross_term = longint'((mag_re * mag_im) >> (FRAC - 1));
            z_re       = sq_re - sq_im + c_re;
            z_im       = cross_term + c_im;
            // The escape test is exact; |z|^2 equal to 4 stays inside.
            mag_re = magnitude_wide(z_re);
            mag_im = magnitude_wide(z_im);
            if ((mag_re * mag_re + mag_im * mag_im) > bound) break;
            iter++;
         end
         return NW'(iter);
      endfunction

      function void note_point(logic signed [CW-1:0] cr, logic signed [CW-1:0] ci);
         expected_counts.push_back(predict_escape_count(cr, ci));
      endfunction

      function void check_count(logic [NW-1:0] actual);
         logic [NW-1:0] wanted;
         if (expected_counts.size() == 0) begin
            $display("%0t escape_count with no point pending: expected none, actual %0d",
                     $time, actual);
            mismatches++;
         end else begin
            wanted = expected_counts.pop_front();
            if (actual !== wanted) begin
               $display("%0t escape_count mismatch: expected %0d, actual %0d",
                        $time, wanted, actual);
               mismatches++;
            end
         end
      endfunction

      function int unsigned pending();
         return expected_counts.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                           csr_write_enable;
   logic [bsec_pkg::CSR_WIDTH-1:0] csr_write_data;

   bsec_req_if #(.COORD_WIDTH(CW)) req_ch ();
   bsec_rsp_if #(.COUNT_WIDTH(NW)) rsp_ch ();

   escape_count_board board = new();

   int unsigned    cycle_count = 0;
   int unsigned    burst_left;
   drain_mode_type drain_mode;
   int unsigned    mode_left;

   burning_ship_escape_count_core #(
      .COORD_WIDTH(CW),
      .COUNT_WIDTH(NW)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   // Clock generation.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // The run ends with a failure if it goes on far too long.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: check every accepted item, and stall on a changing pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         drain_mode   <= DRAIN_FREE;
         mode_left    <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) board.check_count(rsp_ch.escape_count);
         if (mode_left == 0) begin
            drain_mode <= drain_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(50, 400);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (drain_mode)
            DRAIN_FREE:   rsp_ch.ready <= 1'b1;
            DRAIN_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE: rsp_ch.ready <= ($urandom_range(0, 5) == 0);
            default:      rsp_ch.ready <= (cycle_count[2:0] != 3'd0);
         endcase
      end
   end

   // Offers one point and waits until the core takes it. Bursts keep valid
   // high from one item to the next; a burst ends with a gap.
   task automatic send_point(input logic signed [CW-1:0] cr, input logic signed [CW-1:0] ci);
      req_ch.valid  <= 1'b1;
      req_ch.c_real <= cr;
      req_ch.c_imag <= ci;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_point(cr, ci);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_ch.valid <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 90)) @(posedge clock);
         else repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // Stops offering items and waits until every count has come back.
   task automatic drain_points();
      req_ch.valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Programs the iteration limit once the core is idle.
   task automatic write_limit(input logic [bsec_pkg::CSR_WIDTH-1:0] value);
      drain_points();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_limit(value);
   endtask

   // Draws a point, mostly from the square where both parts of c lie in [-2, 2].
   task automatic random_point(output logic signed [CW-1:0] cr,
                               output logic signed [CW-1:0] ci);
      int   pick;
      int   near_edge;
      int   off_axis;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
         cr = $signed($urandom_range(0, 2 * TWO)) - TWO;
         ci = $signed($urandom_range(0, 2 * TWO)) - TWO;
      end else if (pick <= 7) begin
         // The small ship on the negative real axis.
         cr = -$signed($urandom_range(456340275, 483183820));
         ci = $signed($urandom_range(0, 32212255)) - 26843546;
      end else if (pick == 8) begin
         // Points close to the circle of radius two.
         near_edge = ($urandom_range(0, 1) ? TWO : -TWO) + $signed($urandom_range(0, 64)) - 32;
         off_axis  = $signed($urandom_range(0, 2048)) - 1024;
         if ($urandom_range(0, 1)) begin
            cr = near_edge;
            ci = off_axis;
         end else begin
            cr = off_axis;
            ci = near_edge;
         end
      end else begin
         cr = $urandom;
         ci = $urandom;
      end
   endtask

   initial begin
      logic signed [CW-1:0] cr, ci;
      int unsigned          phase_limits[PHASE_COUNT];
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.c_real    <= '0;
      req_ch.c_imag    <= '0;
      burst_left        = 0;
      phase_limits      = '{40, 200, 7, 1, 130, 0};
      phase_limits[PHASE_COUNT-1] = $urandom_range(0, 300);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points at the reset limit.
      send_point('0, '0);
      send_point(C_MAX, C_MAX);
      send_point(C_MIN, C_MIN);
      send_point(C_MAX, C_MIN);
      send_point(C_MIN, '0);
      // Points on the circle |c| = 2, where |z|^2 equal to 4 is not an escape.
      send_point(TWO, '0);
      send_point(-TWO, '0);
      send_point('0, TWO);
      send_point('0, -TWO);
      // Just outside the circle: escape in the first iteration.
      send_point(TWO + 1, '0);
      send_point(-TWO - 1, '0);
      send_point(ONE, ONE);
      send_point(-(ONE * 7 / 4), -(ONE * 3 / 100));
      send_point(32'sh5555_5555, 32'shAAAA_AAAA);
      send_point(32'shAAAA_AAAA, 32'sh5555_5555);

      // A zero limit answers zero for any point.
      write_limit('0);
      send_point('0, '0);
      send_point(C_MAX, C_MAX);

      write_limit(16'd1);
      send_point('0, '0);
      send_point(TWO + 1, '0);

      // The widest limit, with one point that never escapes.
      write_limit(16'hFFFF);
      send_point('0, '0);
      send_point(ONE, ONE);
      send_point(C_MIN, C_MAX);

      // Random points under several limits.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_limit(CSRW'(phase_limits[p]));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Once, let the core run dry in the middle of a phase.
            if (p == 1 && n == PHASE_ITEMS / 2) drain_points();
            random_point(cr, ci);
            send_point(cr, ci);
         end
      end

      drain_points();
      repeat (50) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bsec_pkg.sv
rtl/core/bsec_if.sv
rtl/core/bsec_mul.sv
rtl/core/burning_ship_escape_count_core.sv
tb/tb_top.sv
